// File: hw/rtl/sac_pkg.sv
// Shared types and constants for the set-associative cache tag unit.
package sac_pkg;

    localparam int CNT_W     = 32;  // running totals and per-entry read counts
    localparam int CFG_W     = 2;   // associativity register width
    localparam int WAY_W     = 2;   // way number in a result
    localparam int SET_OUT_W = 4;   // set number in a result

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the input beat and issue the store read
        logic commit;   // update stores and totals, load the result register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free; // result register empty or being drained this cycle
    } t_ctrl_sts;

endpackage

// File: hw/rtl/sac_ram.sv
// Generic single write port, single read port RAM with registered read data.
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/sac_ctrl.sv
// Access sequencer: accept a beat, then evaluate and commit it.
module sac_ctrl
    import sac_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_tvalid,
    output logic      o_s_tready,
    input  t_ctrl_sts i_sts,
    output t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        o_s_tready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                // hold until the result register can take the outcome
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/sac_dpath.sv
// Tag datapath: per-way tag/count RAMs, valid bits, victim choice, totals, result register.
module sac_dpath
    import sac_pkg::*;
#(
    parameter int LINE_COUNT   = 16,
    parameter int OFFSET_WIDTH = 6,
    parameter int ADDR_WIDTH   = 64,
    parameter int MAX_WAYS     = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl_cmd        i_cmd,
    output t_ctrl_sts        o_sts,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_cfg_ready,
    input  logic             i_action,
    input  logic [63:0]      i_address,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic             o_hit,
    output logic [WAY_W-1:0] o_way_used,
    output logic [SET_OUT_W-1:0] o_set_number,
    output logic [CNT_W-1:0] o_hit_total,
    output logic [CNT_W-1:0] o_miss_total,
    output logic [CNT_W-1:0] o_read_total,
    output logic [CNT_W-1:0] o_write_total
);

    localparam int IDX_W  = $clog2(LINE_COUNT + 1) - 1;   // floor(log2(LINE_COUNT))
    localparam int RA_W   = $clog2(LINE_COUNT);
    localparam int TAG_W  = ADDR_WIDTH - OFFSET_WIDTH - IDX_W;
    localparam int ENT_W  = TAG_W + CNT_W;
    localparam logic [2:0] MAX_W3 = 3'(MAX_WAYS);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(MAX_WAYS - 1);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // configuration
    logic [CFG_W-1:0] r_ways_log2;

    // captured access
    logic             r_action;
    logic [TAG_W-1:0] r_tag;
    logic [IDX_W-1:0] r_set;
    logic [RA_W-1:0]  r_ra;
    logic [1:0]       r_lw;

    // stores and totals
    logic [LINE_COUNT-1:0] r_valid [MAX_WAYS];
    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] r_reads;
    logic [CNT_W-1:0] r_writes;

    // result register
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [WAY_W-1:0]     r_out_way;
    logic [SET_OUT_W-1:0] r_out_set;

    logic [1:0]       in_lw;
    logic [IDX_W-1:0] in_line;
    logic [IDX_W-1:0] in_set;
    logic [2:0]       way_lim;
    logic [2:0]       eff_ways;
    logic [ENT_W-1:0] rd_data [MAX_WAYS];
    logic [MAX_WAYS-1:0] match;
    logic [CNT_W-1:0] cnt [4];
    logic             hit_found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
    logic [WAY_W-1:0] sel_way;
    logic [CNT_W-1:0] new_count;
    logic             lowest;
    logic             victim_found;

    assign o_cfg_ready = 1'b1;

    // Decode the incoming address; code 3 saturates to four-way.
    assign in_lw   = (r_ways_log2 > 2'd2) ? 2'd2 : r_ways_log2;
    assign in_line = i_address[OFFSET_WIDTH+IDX_W-1:OFFSET_WIDTH];
    assign in_set  = in_line >> in_lw;

    assign way_lim  = 3'd1 << r_lw;
    assign eff_ways = (way_lim > MAX_W3) ? MAX_W3 : way_lim;

    for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
        logic [TAG_W-1:0] rd_tag;
        logic [CNT_W-1:0] rd_cnt;
        logic             ent_valid;

        sac_ram #(
            .WIDTH (ENT_W),
            .DEPTH (LINE_COUNT)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (i_cmd.commit && sel_way == WAY_W'(w)),
            .i_wr_addr (r_ra),
            .i_wr_data ({r_tag, new_count}),
            .i_rd_en   (i_cmd.load),
            .i_rd_addr (RA_W'(in_set)),
            .o_rd_data (rd_data[w])
        );

        assign rd_tag    = rd_data[w][ENT_W-1:CNT_W];
        assign rd_cnt    = rd_data[w][CNT_W-1:0];
        assign ent_valid = r_valid[w][r_ra];
        assign match[w]  = (3'(w) < way_lim) && ent_valid && (rd_tag == r_tag);
        // a never-filled entry reads as count zero
        assign cnt[w]    = ent_valid ? rd_cnt : '0;
    end

    for (genvar w = MAX_WAYS; w < 4; w++) begin : g_absent
        assign cnt[w] = '0;
    end

    // first matching way wins; a write never hits
    always_comb begin
        hit_found = 1'b0;
        hit_way   = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w] && !r_action) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
        end
    end

    // least-read victim; two-way ties pick way 0, four-way ties pick the last way
    always_comb begin
        victim       = 2'd3;
        victim_found = 1'b0;
        lowest       = 1'b0;
        if (eff_ways == 3'd1) begin
            victim = 2'd0;
        end else if (eff_ways == 3'd2) begin
            victim = (cnt[0] > cnt[1]) ? 2'd1 : 2'd0;
        end else begin
            for (int w = 0; w < 3; w++) begin
                lowest = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    if (k != w && !(cnt[w] < cnt[k])) begin
                        lowest = 1'b0;
                    end
                end
                if (lowest && !victim_found) begin
                    victim_found = 1'b1;
                    victim       = WAY_W'(w);
                end
            end
        end
        if ({1'b0, victim} >= MAX_W3) begin
            victim = LAST_WAY;
        end
    end

    assign sel_way   = hit_found ? hit_way : victim;
    assign new_count = hit_found ? sat_inc(cnt[hit_way]) : cnt[victim];

    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ways_log2 <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_reads     <= '0;
            r_writes    <= '0;
            r_out_valid <= 1'b0;
            for (int w = 0; w < MAX_WAYS; w++) begin
                r_valid[w] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_ways_log2 <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (!r_action) begin
                    r_reads <= sat_inc(r_reads);
                    if (hit_found) begin
                        r_hits <= sat_inc(r_hits);
                    end else begin
                        r_misses <= sat_inc(r_misses);
                    end
                end
                if (!hit_found) begin
                    r_writes <= sat_inc(r_writes);
                    for (int w = 0; w < MAX_WAYS; w++) begin
                        if (victim == WAY_W'(w)) begin
                            r_valid[w][r_ra] <= 1'b1;
                        end
                    end
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: access capture and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_tag    <= i_address[ADDR_WIDTH-1:OFFSET_WIDTH+IDX_W];
            r_set    <= in_set;
            r_ra     <= RA_W'(in_set);
            r_lw     <= in_lw;
        end
        if (i_cmd.commit) begin
            r_out_hit <= hit_found;
            r_out_way <= sel_way;
            r_out_set <= SET_OUT_W'(r_set);
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_way_used    = r_out_way;
    assign o_set_number  = r_out_set;
    // totals change only on commit, which waits until the shown result is drained
    assign o_hit_total   = r_hits;
    assign o_miss_total  = r_misses;
    assign o_read_total  = r_reads;
    assign o_write_total = r_writes;

endmodule

// File: hw/rtl/set_assoc_cache_tag_model_unit.sv
// Top level of the set-associative cache tag unit with least-read replacement.
//
//  channel  | direction | beat fields
//  ---------+-----------+-------------------------------------------------------
//  s        | in        | tuser: action; tdata: address, word_value
//  m        | out       | tuser: hit; tdata: way_used, set_number, four totals
//  cfg      | in        | data: ways_log2 (0 direct, 1 two-way, 2/3 four-way)
//
// An access has an accept cycle, which issues the read of every way's tag/count
// RAM at the set, and an evaluate state, which compares tags, picks the victim and
// writes one way back. The per-way RAM's registered read data sets this split.
// Reset clears the valid bits, the totals and the associativity at once; no
// clearing pass is needed. A stalled result register holds the access in its
// evaluate cycle, while the shown result waits for its beat to be taken.
// The data word is accepted but not retained: no result depends on it.
module set_assoc_cache_tag_model_unit
    import sac_pkg::*;
#(
    parameter int LINE_COUNT   = 16,
    parameter int OFFSET_WIDTH = 6,
    parameter int ADDR_WIDTH   = 64,
    parameter int MAX_WAYS     = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input access beat
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [95:0]      i_s_tdata,   // [63:0] address, [95:64] word_value
    input  logic [0:0]       i_s_tuser,   // [0] action
    // result beat
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // [1:0] way_used, [5:2] set_number, [37:6] hit_total, [69:38] miss_total,
    // [101:70] read_total, [133:102] write_total, [135:134] zero
    output logic [135:0]     o_m_tdata,
    output logic [0:0]       o_m_tuser,   // [0] hit
    // associativity register write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    logic                 hit;
    logic [WAY_W-1:0]     way_used;
    logic [SET_OUT_W-1:0] set_number;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
    logic [CNT_W-1:0]     read_total;
    logic [CNT_W-1:0]     write_total;

    // sequence each access: accept, then evaluate and commit
    sac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // stores, lookup, victim choice and result register
    sac_dpath #(
        .LINE_COUNT   (LINE_COUNT),
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .i_action      (i_s_tuser[0]),
        .i_address     (i_s_tdata[63:0]),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_hit         (hit),
        .o_way_used    (way_used),
        .o_set_number  (set_number),
        .o_hit_total   (hit_total),
        .o_miss_total  (miss_total),
        .o_read_total  (read_total),
        .o_write_total (write_total)
    );

    // pack the result beat, lowest field first
    assign o_m_tdata = {2'b00, write_total, read_total, miss_total, hit_total,
                        set_number, way_used};
    assign o_m_tuser = hit;

endmodule

// File: verif/sac_tag_checker.sv
`timescale 1ns / 100ps
// Watches the cache tag unit's channels, predicts each result beat and compares it.
module sac_tag_checker
    import sac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [95:0]      i_s_tdata,   // [63:0] address, [95:64] word_value
    input  logic [0:0]       i_s_tuser,   // [0] action
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    // [1:0] way_used, [5:2] set_number, [37:6] hit_total, [69:38] miss_total,
    // [101:70] read_total, [133:102] write_total, [135:134] zero
    input  logic [135:0]     i_m_tdata,
    input  logic [0:0]       i_m_tuser,   // [0] hit
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int WAYS  = 4;
    localparam int LINES = 16;

    typedef struct packed {
        logic                 hit;
        logic [WAY_W-1:0]     way;
        logic [SET_OUT_W-1:0] set_no;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
        logic [CNT_W-1:0]     reads;
        logic [CNT_W-1:0]     writes;
    } t_access_result;

    logic             line_valid [WAYS][LINES];
    logic [53:0]      line_tag   [WAYS][LINES];
    logic [CNT_W-1:0] line_reads [WAYS][LINES];
    logic [31:0]      line_word  [WAYS][LINES];
    logic [CNT_W-1:0] hit_count, miss_count, read_count, fill_count;
    logic [CFG_W-1:0] ways_code;

    t_access_result awaited_results [$];
    int             result_beats;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] result beat %0d: %s", $realtime, result_beats, msg);
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Look the address up in the tag store, fill a victim on a miss or a write,
    // and return the result beat that access produces.
    task automatic cache_access(input logic is_write, input logic [63:0] addr,
                                input logic [31:0] word, output t_access_result r);
        int          lw;
        int          nways;
        int          set_i;
        int          way_i;
        logic [53:0] tag;
        logic [3:0]  line;
        logic        hit;
        logic        lowest;
        logic        found;
        lw    = (ways_code > 2) ? 2 : int'(ways_code);
        nways = 1 << lw;
        line  = addr[9:6];
        set_i = int'(line) >> lw;
        tag   = addr[63:10];
        hit   = 1'b0;
        way_i = 0;
        if (!is_write) begin
            read_count = sat_inc(read_count);
            for (int w = 0; w < nways; w++) begin
                if (!hit && line_valid[w][set_i] && line_tag[w][set_i] == tag) begin
                    hit   = 1'b1;
                    way_i = w;
                end
            end
            if (hit) begin
                hit_count = sat_inc(hit_count);
                line_reads[way_i][set_i] = sat_inc(line_reads[way_i][set_i]);
            end else begin
                miss_count = sat_inc(miss_count);
            end
        end
        if (!hit) begin
            fill_count = sat_inc(fill_count);
            if (nways == 1) begin
                way_i = 0;
            end else if (nways == 2) begin
                way_i = (line_reads[0][set_i] > line_reads[1][set_i]) ? 1 : 0;
            end else begin
                // first way strictly below the other three, else the last way
                way_i = 3;
                found = 1'b0;
                for (int w = 0; w < 3; w++) begin
                    lowest = 1'b1;
                    for (int k = 0; k < 4; k++)
                        if (k != w && !(line_reads[w][set_i] < line_reads[k][set_i]))
                            lowest = 1'b0;
                    if (lowest && !found) begin
                        way_i = w;
                        found = 1'b1;
                    end
                end
            end
            line_tag[way_i][set_i]   = tag;
            line_valid[way_i][set_i] = 1'b1;
            line_word[way_i][set_i]  = word;
        end
        r.hit    = hit;
        r.way    = WAY_W'(way_i);
        r.set_no = SET_OUT_W'(set_i);
        r.hits   = hit_count;
        r.misses = miss_count;
        r.reads  = read_count;
        r.writes = fill_count;
    endtask

    always @(posedge i_clk) begin
        t_access_result exp_r;
        t_access_result new_r;
        if (!i_rst_n) begin
            for (int w = 0; w < WAYS; w++)
                for (int l = 0; l < LINES; l++) begin
                    line_valid[w][l] = 1'b0;
                    line_tag[w][l]   = '0;
                    line_reads[w][l] = '0;
                    line_word[w][l]  = '0;
                end
            hit_count  = '0;
            miss_count = '0;
            read_count = '0;
            fill_count = '0;
            ways_code  = '0;
            result_beats = 0;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                ways_code = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                cache_access(i_s_tuser[0], i_s_tdata[63:0], i_s_tdata[95:64], new_r);
                awaited_results.push_back(new_r);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no access awaiting it");
                end else begin
                    exp_r = awaited_results.pop_front();
                    compare_field("hit",         i_m_tuser[0],       exp_r.hit);
                    compare_field("way_used",    i_m_tdata[1:0],     exp_r.way);
                    compare_field("set_number",  i_m_tdata[5:2],     exp_r.set_no);
                    compare_field("hit_total",   i_m_tdata[37:6],    exp_r.hits);
                    compare_field("miss_total",  i_m_tdata[69:38],   exp_r.misses);
                    compare_field("read_total",  i_m_tdata[101:70],  exp_r.reads);
                    compare_field("write_total", i_m_tdata[133:102], exp_r.writes);
                end
                result_beats++;
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the cache tag unit: clock, reset, stimulus, watchdog and verdict.
module testbench;
    import sac_pkg::*;

    localparam int STALL_LIMIT   = 2000; // cycles without any beat before giving up
    localparam int TAIL_CYCLES   = 20;   // quiet cycles after the last result
    localparam int SETTLE_CYCLES = 4;    // settling margin once no result is awaited
    localparam int PHASE_ITEMS   = 300;
    localparam int PHASE_COUNT   = 6;
    localparam int CALM_ITEMS    = 200;  // final stretch with no idling at all
    localparam int POOL_SIZE     = 8;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [CFG_W-1:0] WAYS_DIRECT   = 2'd0;
    localparam logic [CFG_W-1:0] WAYS_TWO      = 2'd1;
    localparam logic [CFG_W-1:0] WAYS_FOUR     = 2'd2;
    localparam logic [CFG_W-1:0] WAYS_FOUR_SAT = 2'd3; // out-of-range code, acts as four-way

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [95:0]      s_tdata     = '0;   // [63:0] address, [95:64] word_value
    logic [0:0]       s_tuser     = '0;   // [0] action
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    // [1:0] way_used, [5:2] set_number, [37:6] hit_total, [69:38] miss_total,
    // [101:70] read_total, [133:102] write_total, [135:134] zero
    logic [135:0]     m_tdata;
    logic [0:0]       m_tuser;            // [0] hit
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data    = '0;

    int fail_count;
    int pending;

    int  accesses_sent = 0;
    int  reads_sent    = 0;
    int  writes_sent   = 0;
    int  ways_writes   = 0;
    bit  calm          = 1'b0;
    logic [53:0] tag_pool [POOL_SIZE];

    set_assoc_cache_tag_model_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    sac_tag_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drop valid at the next falling edge and keep the sender idle for the stretch set by n.
    task automatic idle_for(input int n);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Hold off the sender until every awaited result beat has been taken.
    task automatic wait_drained();
        idle_for(1);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Change the associativity only with the unit empty.
    task automatic write_ways(input logic [CFG_W-1:0] code);
        wait_drained();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        ways_writes++;
    endtask

    // Present one access beat and hold it until the unit takes it. Valid stays
    // high afterwards so back-to-back beats need no extra edge.
    task automatic send_access(input logic act, input logic [63:0] addr,
                               input logic [31:0] word);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {word, addr};
        s_tuser  <= act;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        accesses_sent++;
        if (act == ACT_READ)
            reads_sent++;
        else
            writes_sent++;
    endtask

    // Pick a fresh set of tags for a phase; keep all-zero and all-one tags in it
    // so every tag bit toggles.
    task automatic refresh_tags();
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            tag_pool[k] = 54'({$urandom, $urandom});
    endtask

    // Mostly reuse pooled tags so lookups hit and the replacement choice matters;
    // now and then throw in a fully random address.
    function automatic logic [63:0] random_address();
        logic [3:0]  line;
        logic [5:0]  offset;
        logic [63:0] addr;
        line   = 4'($urandom_range(0, 15));
        offset = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0)
            addr = {$urandom, $urandom};
        else
            addr = {tag_pool[$urandom_range(0, POOL_SIZE - 1)], line, offset};
        return addr;
    endfunction

    // Receiver: stall in random bursts, take beats freely in between, and never
    // stall in the calm tail.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (calm) begin
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no beat for %0d cycles", STALL_LIMIT);
        $display("set_assoc_cache_tag_model_unit: mismatch");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] phase_codes [PHASE_COUNT];
        int  item;
        bit  gappy;
        phase_codes = '{WAYS_TWO, WAYS_FOUR, WAYS_DIRECT, WAYS_FOUR_SAT, WAYS_FOUR, WAYS_TWO};
        item  = 0;
        gappy = 1'b0;

        // hold reset, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: direct mapped, zero and all-ones addresses, word extremes,
        // a write over a valid line and a read that misses on the offset edge.
        write_ways(WAYS_DIRECT);
        send_access(ACT_READ,  64'h0,                  32'h0000_0000);
        send_access(ACT_READ,  64'h0,                  32'h7FFF_FFFF);
        send_access(ACT_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
        send_access(ACT_READ,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_access(ACT_WRITE, 64'h8000_0000_0000_0000, 32'h0000_0000);
        send_access(ACT_READ,  64'h0000_0000_0000_003F, 32'h1234_5678);
        send_access(ACT_READ,  64'h0000_0000_0000_003F, 32'h8765_4321);

        // Two-way: each miss in set 0 fills way 1, since way 0 was read more; one read hits.
        write_ways(WAYS_TWO);
        send_access(ACT_READ,  64'h400, 32'hA5A5_A5A5);
        send_access(ACT_READ,  64'h840, 32'h5A5A_5A5A);
        send_access(ACT_READ,  64'h400, 32'h0000_0001);
        send_access(ACT_READ,  64'h840, 32'h0000_0002);
        send_access(ACT_READ,  64'h840, 32'h0000_0003);
        send_access(ACT_WRITE, 64'hC00, 32'hFFFF_0000);

        // Four-way: five tags in set 0; with no way strictly least read, every miss fills way 3.
        write_ways(WAYS_FOUR);
        send_access(ACT_READ, 64'h0400, 32'h1);
        send_access(ACT_READ, 64'h0800, 32'h2);
        send_access(ACT_READ, 64'h0C00, 32'h3);
        send_access(ACT_READ, 64'h1000, 32'h4);
        send_access(ACT_READ, 64'h0800, 32'h5);
        send_access(ACT_READ, 64'h1400, 32'h6);
        send_access(ACT_READ, 64'h0400, 32'h7);

        // Code 3 saturates to four-way.
        write_ways(WAYS_FOUR_SAT);
        send_access(ACT_READ,  64'h0800, 32'h8);
        send_access(ACT_WRITE, 64'h1800, 32'h9);

        // Random phases, one associativity setting each.
        foreach (phase_codes[p]) begin
            write_ways(phase_codes[p]);
            refresh_tags();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                calm = (item >= PHASE_COUNT * PHASE_ITEMS - CALM_ITEMS);
                // switch between gappy and back-to-back stretches
                if (i % 60 == 0)
                    gappy = 1'($urandom_range(0, 1));
                // outside the calm tail, hold the sender once per phase until the unit has drained
                if (i == PHASE_ITEMS / 2 && !calm)
                    wait_drained();
                send_access(($urandom_range(0, 3) == 0) ? ACT_WRITE : ACT_READ,
                            random_address(), $urandom);
                if (!calm && gappy && $urandom_range(0, 2) == 0)
                    idle_for($urandom_range(1, 12));
                item++;
            end
        end

        // drain, then give the unit a quiet tail
        idle_for(1);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d accesses (%0d reads, %0d writes) across %0d associativity writes",
                 accesses_sent, reads_sent, writes_sent, ways_writes);
        $display("settings used: direct mapped, two-way, four-way and the saturated code");
        if (fail_count == 0 && pending == 0)
            $display("set_assoc_cache_tag_model_unit: match");
        else
            $display("set_assoc_cache_tag_model_unit: mismatch");
        $finish;
    end

endmodule
